@@ hw/rtl/brfc_pkg.sv @@
package brfc_pkg;

    localparam int TYPE_W     = 3;
    localparam int LEN_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 14;
    localparam int CFG_W      = 15;

    localparam int DEPTH_DEF     = 16384;
    localparam int MAX_CHUNK_DEF = 64;
    localparam int BLINK         = 1;
    localparam int SIZE_MIN      = 128;
    localparam int SIZE_RESET    = 16384;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ENQ    = 3'd0,
        REQ_DEQ    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_ADV_WR = 3'd3,
        REQ_ADV_RD = 3'd4,
        REQ_CLEAR  = 3'd5
    } req_t;

endpackage

@@ hw/rtl/brfc_ram.sv @@
module brfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/brfc_count.sv @@
module brfc_count #(
    parameter int DEPTH = brfc_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [$clog2(DEPTH):0]     size,
    input  logic [$clog2(DEPTH)-1:0]   rd_pos,
    input  logic [$clog2(DEPTH)-1:0]   wr_pos,
    output logic [$clog2(DEPTH)-1:0]   used_cnt,
    output logic [$clog2(DEPTH)-1:0]   free_cnt
);

    import brfc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;

    logic [SW-1:0] diff;
    logic          wrapped;
    logic [SW-1:0] used_next;
    logic [SW-1:0] free_next;

    always_comb
    begin
        diff    = {1'b0, wr_pos} - {1'b0, rd_pos};
        wrapped = rd_pos > wr_pos;
        if (wrapped)
        begin
            used_next = size + diff;
            free_next = {1'b0, rd_pos} - {1'b0, wr_pos} - SW'(BLINK);
        end
        else
        begin
            used_next = diff;
            free_next = size - SW'(BLINK) - diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_cnt <= '0;
            free_cnt <= '0;
        end
        else
        begin
            used_cnt <= used_next[AW-1:0];
            free_cnt <= free_next[AW-1:0];
        end
    end

endmodule

@@ hw/rtl/byte_ring_fifo_chunked.sv @@
// Byte ring buffer, one slot kept empty (capacity is size_in_use - 1).
// Request channel: in_valid / in_stall with req_type, length, in_byte.
// Result channel: out_valid / out_stall with out_byte, last, accepted,
// used_count, free_count. Configuration: cfg_we / cfg_data write the ring
// size (saturated to 128..DEPTH) and empty the ring; the request channel
// stalls while cfg_we is high and in the cycle after such a write.
// After reset the block sweeps the byte memory to zero, one entry a cycle,
// with in_stall high throughout; config writes are taken meanwhile.
// Enqueue byte, advance, clear and refused requests give one result, via
// ST_COUNT and ST_RESP; no new request is taken before that result loads.
// Dequeue and peek of L bytes give L results, read in ST_READ after
// ST_COUNT, one byte a cycle while out_stall is low, limited by the one
// read port of the byte memory; no new request is taken before the last.
// The result register holds while out_stall is high; a one-entry hold
// register catches a read byte that arrives then, and memory reads pause
// until it drains. No result is lost or repeated under any stall pattern.
module byte_ring_fifo_chunked #(
    parameter int DEPTH     = brfc_pkg::DEPTH_DEF,
    parameter int MAX_CHUNK = brfc_pkg::MAX_CHUNK_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brfc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brfc_pkg::TYPE_W-1:0] req_type,
    input  logic [brfc_pkg::LEN_W-1:0]  length,
    input  logic [brfc_pkg::BYTE_W-1:0] in_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [brfc_pkg::BYTE_W-1:0] out_byte,
    output logic                        last,
    output logic                        accepted,
    output logic [brfc_pkg::CNT_W-1:0]  used_count,
    output logic [brfc_pkg::CNT_W-1:0]  free_count
);

    import brfc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam int RW = $clog2(MAX_CHUNK + 1);
    localparam int XW = (SW > CFG_W) ? SW : CFG_W;
    localparam logic [SW-1:0] SIZE_RST =
        (SIZE_RESET > DEPTH) ? SW'(DEPTH) : SW'(SIZE_RESET);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_COUNT,
        ST_RESP,
        ST_READ
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [AW-1:0]     rd_pos_reg, rd_pos_next;
    logic [AW-1:0]     wr_pos_reg, wr_pos_next;
    logic [RW-1:0]     run_left_reg, run_left_next;
    logic              run_ok_reg, run_ok_next;
    logic              cfg_pend_reg, cfg_pend_next;
    logic              res_last_reg, res_last_next;
    logic              res_acc_reg, res_acc_next;
    logic              rd_go_reg, rd_go_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [RW-1:0]     left_reg, left_next;
    logic              inflight_reg, inflight_next;
    logic              inflight_last_reg, inflight_last_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic              hold_last_reg, hold_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_acc_reg, out_acc_next;
    logic [CNT_W-1:0]  out_used_reg, out_used_next;
    logic [CNT_W-1:0]  out_free_reg, out_free_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    logic [AW-1:0]       used_cnt;
    logic [AW-1:0]       free_cnt;
    logic [AW+CNT_W-1:0] used_ext;
    logic [AW+CNT_W-1:0] free_ext;
    logic [AW-1:0]       len_ext;
    logic [XW-1:0]       cfg_ext;
    logic                in_accept;
    logic                out_load;
    logic                len_bad;
    logic [RW-1:0]       run_cur;
    logic                run_grant;
    logic                rd_issue;

    function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0]    p,
                                               input logic [LEN_W-1:0] n,
                                               input logic [SW-1:0]    sz);
        logic [SW-1:0] s;
        s = {1'b0, p} + {{(SW-LEN_W){1'b0}}, n};
        if (s >= sz)
        begin
            s = s - sz;
        end
        return s[AW-1:0];
    endfunction

    brfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_reg),
        .rdata (ram_rdata)
    );

    brfc_count #(
        .DEPTH (DEPTH)
    ) u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .size     (size_reg),
        .rd_pos   (rd_pos_reg),
        .wr_pos   (wr_pos_reg),
        .used_cnt (used_cnt),
        .free_cnt (free_cnt)
    );

    assign used_ext = {{CNT_W{1'b0}}, used_cnt};
    assign free_ext = {{CNT_W{1'b0}}, free_cnt};
    assign len_ext  = {{(AW-LEN_W){1'b0}}, length};
    assign cfg_ext  = XW'(cfg_data);

    assign in_stall  = (state_reg != ST_IDLE) || cfg_pend_reg || cfg_we;
    assign in_accept = in_valid && !in_stall;
    assign out_load  = !out_valid_reg || !out_stall;
    assign len_bad   = (length == '0) || (length > LEN_W'(MAX_CHUNK));
    assign run_cur   = (run_left_reg == '0) ? RW'(length) : run_left_reg;
    assign run_grant = (run_left_reg == '0) ? (free_cnt >= len_ext) : run_ok_reg;
    assign rd_issue  = (left_reg != '0)
                       && ((!hold_valid_reg && !inflight_reg)
                           || (out_load && (hold_valid_reg || inflight_reg)));

    always_comb
    begin
        state_next         = state_reg;
        clr_addr_next      = clr_addr_reg;
        size_next          = size_reg;
        rd_pos_next        = rd_pos_reg;
        wr_pos_next        = wr_pos_reg;
        run_left_next      = run_left_reg;
        run_ok_next        = run_ok_reg;
        cfg_pend_next      = 1'b0;
        res_last_next      = res_last_reg;
        res_acc_next       = res_acc_reg;
        rd_go_next         = rd_go_reg;
        cur_next           = cur_reg;
        left_next          = left_reg;
        inflight_next      = 1'b0;
        inflight_last_next = inflight_last_reg;
        hold_valid_next    = hold_valid_reg;
        hold_byte_next     = hold_byte_reg;
        hold_last_next     = hold_last_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_byte_next      = out_byte_reg;
        out_last_next      = out_last_reg;
        out_acc_next       = out_acc_reg;
        out_used_next      = out_used_reg;
        out_free_next      = out_free_reg;
        ram_we             = 1'b0;
        ram_waddr          = wr_pos_reg;
        ram_wdata          = in_byte;
        ram_re             = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next    = ST_COUNT;
                    rd_go_next    = 1'b0;
                    res_last_next = 1'b1;
                    res_acc_next  = 1'b0;
                    unique case (req_type)
                        REQ_ENQ:
                        begin
                            if (run_left_reg != '0 || !len_bad)
                            begin
                                res_acc_next  = run_grant;
                                res_last_next = (run_cur == RW'(1));
                                run_left_next = run_cur - 1'b1;
                                run_ok_next   = (run_cur == RW'(1)) ? 1'b0 : run_grant;
                                if (run_grant)
                                begin
                                    ram_we      = 1'b1;
                                    wr_pos_next = wrap_pos(wr_pos_reg, LEN_W'(1), size_reg);
                                end
                            end
                        end
                        REQ_DEQ, REQ_PEEK:
                        begin
                            if (!len_bad && used_cnt >= len_ext)
                            begin
                                rd_go_next = 1'b1;
                                cur_next   = rd_pos_reg;
                                left_next  = RW'(length);
                                if (req_type == REQ_DEQ)
                                begin
                                    rd_pos_next = wrap_pos(rd_pos_reg, length, size_reg);
                                end
                            end
                        end
                        REQ_ADV_WR:
                        begin
                            if (length != '0)
                            begin
                                res_acc_next = 1'b1;
                                wr_pos_next  = wrap_pos(wr_pos_reg, length, size_reg);
                            end
                        end
                        REQ_ADV_RD:
                        begin
                            if (length != '0)
                            begin
                                res_acc_next = 1'b1;
                                rd_pos_next  = wrap_pos(rd_pos_reg, length, size_reg);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            res_acc_next  = 1'b1;
                            rd_pos_next   = '0;
                            wr_pos_next   = '0;
                            run_left_next = '0;
                            run_ok_next   = 1'b0;
                        end
                        default:
                        begin
                            res_acc_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_COUNT:
            begin
                state_next = rd_go_reg ? ST_READ : ST_RESP;
            end

            ST_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = res_last_reg;
                    out_acc_next   = res_acc_reg;
                    out_used_next  = used_ext[CNT_W-1:0];
                    out_free_next  = free_ext[CNT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            ST_READ:
            begin
                // drain hold first, then the byte arriving from memory
                if (hold_valid_reg)
                begin
                    if (out_load)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = hold_byte_reg;
                        out_last_next   = hold_last_reg;
                        hold_valid_next = inflight_reg;
                        hold_byte_next  = ram_rdata;
                        hold_last_next  = inflight_last_reg;
                    end
                end
                else if (inflight_reg)
                begin
                    if (out_load)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = ram_rdata;
                        out_last_next  = inflight_last_reg;
                    end
                    else
                    begin
                        hold_valid_next = 1'b1;
                        hold_byte_next  = ram_rdata;
                        hold_last_next  = inflight_last_reg;
                    end
                end
                if (out_load && (hold_valid_reg || inflight_reg))
                begin
                    out_acc_next  = 1'b1;
                    out_used_next = used_ext[CNT_W-1:0];
                    out_free_next = free_ext[CNT_W-1:0];
                end
                if (rd_issue)
                begin
                    ram_re             = 1'b1;
                    cur_next           = wrap_pos(cur_reg, LEN_W'(1), size_reg);
                    left_next          = left_reg - 1'b1;
                    inflight_next      = 1'b1;
                    inflight_last_next = (left_reg == RW'(1));
                end
                if (left_next == '0 && !inflight_next && !hold_valid_next)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // size write empties the ring
        if (cfg_we)
        begin
            cfg_pend_next = 1'b1;
            rd_pos_next   = '0;
            wr_pos_next   = '0;
            run_left_next = '0;
            run_ok_next   = 1'b0;
            priority if (cfg_ext > XW'(DEPTH))
            begin
                size_next = SW'(DEPTH);
            end
            else if (cfg_ext < XW'(SIZE_MIN))
            begin
                size_next = SW'(SIZE_MIN);
            end
            else
            begin
                size_next = cfg_ext[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLR;
            clr_addr_reg      <= '0;
            size_reg          <= SIZE_RST;
            rd_pos_reg        <= '0;
            wr_pos_reg        <= '0;
            run_left_reg      <= '0;
            run_ok_reg        <= 1'b0;
            cfg_pend_reg      <= 1'b0;
            res_last_reg      <= 1'b0;
            res_acc_reg       <= 1'b0;
            rd_go_reg         <= 1'b0;
            cur_reg           <= '0;
            left_reg          <= '0;
            inflight_reg      <= 1'b0;
            inflight_last_reg <= 1'b0;
            hold_valid_reg    <= 1'b0;
            hold_byte_reg     <= '0;
            hold_last_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_byte_reg      <= '0;
            out_last_reg      <= 1'b0;
            out_acc_reg       <= 1'b0;
            out_used_reg      <= '0;
            out_free_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_addr_reg      <= clr_addr_next;
            size_reg          <= size_next;
            rd_pos_reg        <= rd_pos_next;
            wr_pos_reg        <= wr_pos_next;
            run_left_reg      <= run_left_next;
            run_ok_reg        <= run_ok_next;
            cfg_pend_reg      <= cfg_pend_next;
            res_last_reg      <= res_last_next;
            res_acc_reg       <= res_acc_next;
            rd_go_reg         <= rd_go_next;
            cur_reg           <= cur_next;
            left_reg          <= left_next;
            inflight_reg      <= inflight_next;
            inflight_last_reg <= inflight_last_next;
            hold_valid_reg    <= hold_valid_next;
            hold_byte_reg     <= hold_byte_next;
            hold_last_reg     <= hold_last_next;
            out_valid_reg     <= out_valid_next;
            out_byte_reg      <= out_byte_next;
            out_last_reg      <= out_last_next;
            out_acc_reg       <= out_acc_next;
            out_used_reg      <= out_used_next;
            out_free_reg      <= out_free_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign last       = out_last_reg;
    assign accepted   = out_acc_reg;
    assign used_count = out_used_reg;
    assign free_count = out_free_reg;

    a_hold_inflight_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_valid_reg && inflight_reg))
        else $error("hold and in-flight read both occupied");

    a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rd_pos_reg} < size_reg) && ({1'b0, wr_pos_reg} < size_reg))
        else $error("ring position beyond ring size");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP || state_reg == ST_READ)
        |-> ({1'b0, used_cnt} + {1'b0, free_cnt} == size_reg - SW'(BLINK)))
        else $error("used and free counts disagree with ring size");

    a_run_ok_open: assert property (@(posedge clk) disable iff (!rst_n)
        run_ok_reg |-> (run_left_reg != '0))
        else $error("granted run without bytes left");

endmodule
